// ===== hdl/mqfs_pkg.sv =====
// Shared types, constants and register codes for the median-qualified fan speed block.
package mqfs_pkg;

  localparam int unsigned SamplesDefault = 10;

  localparam int unsigned CodeW   = 10;
  localparam int unsigned EchoW   = 16;
  localparam int unsigned DutyW   = 8;
  localparam int unsigned DistW   = 11;  // full distance, up to 1114 cm
  localparam int unsigned DistOutW = 9;
  localparam int unsigned NearW   = 9;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 11;

  // Register indexes on the config port
  localparam logic [CfgIdxW-1:0] REG_BAND_LOW  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BAND_MID  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BAND_HIGH = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OUTLIER   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_NEAR      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MAX       = 3'd5;

  // Reset values
  localparam logic [CodeW-1:0] BAND_LOW_RST  = 10'd144;
  localparam logic [CodeW-1:0] BAND_MID_RST  = 10'd154;
  localparam logic [CodeW-1:0] BAND_HIGH_RST = 10'd164;
  localparam logic [CodeW-1:0] OUTLIER_RST   = 10'd11;
  localparam logic [NearW-1:0] NEAR_RST      = 9'd50;
  localparam logic [DistW-1:0] MAX_RST       = 11'd300;

  // Duty levels
  localparam logic [DutyW-1:0] DUTY_OFF  = 8'd0;
  localparam logic [DutyW-1:0] DUTY_LOW  = 8'd80;
  localparam logic [DutyW-1:0] DUTY_MID  = 8'd160;
  localparam logic [DutyW-1:0] DUTY_FULL = 8'd255;

  // floor(echo*17/1000) == (echo * DIST_MULT) >> DIST_SHIFT for all 16-bit echo
  localparam int unsigned DistShift = 26;
  localparam int unsigned MultW     = 21;
  localparam logic [MultW-1:0] DIST_MULT = 21'd1140851;
  localparam int unsigned ProdW     = EchoW + MultW;

  localparam logic [DistW-1:0] DIST_SAT = 11'd511;

  typedef struct packed {
    logic [CodeW-1:0] band_low;
    logic [CodeW-1:0] band_mid;
    logic [CodeW-1:0] band_high;
    logic [CodeW-1:0] outlier;
    logic [NearW-1:0] near_cm;
    logic [DistW-1:0] max_cm;
  } mqfs_cfg_t;

  // Value and "goes after the new code" flag handed from one cell to the next
  typedef struct packed {
    logic [CodeW-1:0] val;
    logic             gt;
  } mqfs_link_t;

  typedef struct packed {
    logic [DutyW-1:0]    duty;
    logic [CodeW-1:0]    temp;
    logic [DistOutW-1:0] dist_cm;
    logic                err;
  } mqfs_res_t;

endpackage

// ===== hdl/mqfs_cell.sv =====
// One cell of the sorted insertion chain.
module mqfs_cell import mqfs_pkg::*; #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned CNTW = 4
) (
  input  logic             clk,
  input  logic             ins_en,
  input  logic [CodeW-1:0] code,
  input  logic [CNTW-1:0]  count,
  input  mqfs_link_t       left,
  output mqfs_link_t       right,
  output logic [CodeW-1:0] val_nxt
);

  logic [CodeW-1:0] val_r;
  logic             occ;

  assign occ       = (CNTW'(IDX) < count);
  assign right.val = val_r;
  // empty cells and larger values make way for the new code
  assign right.gt  = !occ || (val_r > code);

  always_comb begin
    if (!right.gt) begin
      val_nxt = val_r;
    end else if (!left.gt) begin
      val_nxt = code;
    end else begin
      val_nxt = left.val;
    end
  end

  always_ff @(posedge clk) begin
    if (ins_en) begin
      val_r <= val_nxt;
    end
  end

endmodule

// ===== hdl/mqfs_chain.sv =====
// Row of insertion cells holding the sorted codes; taps the median.
module mqfs_chain import mqfs_pkg::*; #(
  parameter int unsigned SAMPLES = SamplesDefault,
  parameter int unsigned CNTW    = $clog2(SAMPLES + 1)
) (
  input  logic             clk,
  input  logic             ins_en,
  input  logic [CodeW-1:0] code,
  input  logic [CNTW-1:0]  count,
  output logic [CodeW-1:0] median_nxt
);

  localparam int unsigned MidIdx = SAMPLES / 2;

  mqfs_link_t       link [SAMPLES+1];
  logic [CodeW-1:0] nxt  [SAMPLES];

  assign link[0] = '{val: '0, gt: 1'b0};

  for (genvar i = 0; i < SAMPLES; i++) begin : g_cell
    mqfs_cell #(
      .IDX  (i),
      .CNTW (CNTW)
    ) u_cell (
      .clk     (clk),
      .ins_en  (ins_en),
      .code    (code),
      .count   (count),
      .left    (link[i]),
      .right   (link[i+1]),
      .val_nxt (nxt[i])
    );
  end

  assign median_nxt = nxt[MidIdx];

endmodule

// ===== hdl/mqfs_decide.sv =====
// Distance conversion and fan duty decision.
module mqfs_decide import mqfs_pkg::*; (
  input  logic [CodeW-1:0] temp,
  input  logic [EchoW-1:0] echo,
  input  mqfs_cfg_t        cfg,
  output mqfs_res_t        res
);

  logic [ProdW-1:0] prod;
  logic [DistW-1:0] dist_full;
  logic             err;
  logic             near;
  logic [DutyW-1:0] band_duty;

  assign prod      = ProdW'(echo) * ProdW'(DIST_MULT);
  assign dist_full = prod[DistShift +: DistW];
  assign err       = dist_full > cfg.max_cm;
  assign near      = dist_full < DistW'(cfg.near_cm);

  always_comb begin
    priority if (temp < cfg.band_low) begin
      band_duty = DUTY_OFF;
    end else if (temp < cfg.band_mid) begin
      band_duty = DUTY_LOW;
    end else if (temp < cfg.band_high) begin
      band_duty = DUTY_MID;
    end else begin
      band_duty = DUTY_FULL;
    end
  end

  always_comb begin
    res.temp = temp;
    res.err  = err;
    res.duty = (err || near) ? DUTY_OFF : band_duty;
    if (err) begin
      res.dist_cm = '0;
    end else if (dist_full > DIST_SAT) begin
      res.dist_cm = DIST_SAT[DistOutW-1:0];
    end else begin
      res.dist_cm = dist_full[DistOutW-1:0];
    end
  end

endmodule

// ===== hdl/median_qualified_fan_speed_top.sv =====
// Median-qualified fan speed controller: top level with config registers and output stage.
//
// Takes one beat per clock while in_stall is low. A beat that yields a result shows it
// on the out_ side in the cycle after it is taken, held in an output register; while that
// register is full and stalled, in_stall is raised. Each beat taken while gathering is
// inserted into the sorted insertion chain of SAMPLES cells as it is taken.
// At start and after every outlier, SAMPLES beats are gathered without a result; the
// last of them returns the median. Later beats whose code stays within outlier_delta
// of that median return a result directly; an outlier beat returns nothing and starts
// a new gather. Config writes are always taken (cfg_ready high) and belong in idle time.
module median_qualified_fan_speed_top import mqfs_pkg::*; #(
  parameter int unsigned SAMPLES = SamplesDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CodeW-1:0]    in_adc_sample,
  input  logic [EchoW-1:0]    in_echo_time,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DutyW-1:0]    out_fan_duty,
  output logic [CodeW-1:0]    out_temperature_code,
  output logic [DistOutW-1:0] out_distance_cm,
  output logic                out_distance_error,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int unsigned CntW = $clog2(SAMPLES + 1);

  mqfs_cfg_t        cfg_r;
  logic             gathering_r, gathering_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic [CodeW-1:0] last_valid_r, last_valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  mqfs_res_t        out_r;

  logic             in_acc;
  logic             ins_en;
  logic [CodeW-1:0] median_nxt;
  logic [CodeW-1:0] diff;
  logic [CntW-1:0]  count_inc;
  logic             gather_done;
  logic             res_en;
  logic [CodeW-1:0] temp_sel;
  mqfs_res_t        res;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign ins_en    = in_acc && gathering_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.band_low  <= BAND_LOW_RST;
      cfg_r.band_mid  <= BAND_MID_RST;
      cfg_r.band_high <= BAND_HIGH_RST;
      cfg_r.outlier   <= OUTLIER_RST;
      cfg_r.near_cm   <= NEAR_RST;
      cfg_r.max_cm    <= MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BAND_LOW:  cfg_r.band_low  <= cfg_data[CodeW-1:0];
        REG_BAND_MID:  cfg_r.band_mid  <= cfg_data[CodeW-1:0];
        REG_BAND_HIGH: cfg_r.band_high <= cfg_data[CodeW-1:0];
        REG_OUTLIER:   cfg_r.outlier   <= cfg_data[CodeW-1:0];
        REG_NEAR:      cfg_r.near_cm   <= cfg_data[NearW-1:0];
        REG_MAX:       cfg_r.max_cm    <= cfg_data[DistW-1:0];
        default:       ;
      endcase
    end
  end

  mqfs_chain #(
    .SAMPLES (SAMPLES),
    .CNTW    (CntW)
  ) u_chain (
    .clk        (clk),
    .ins_en     (ins_en),
    .code       (in_adc_sample),
    .count      (count_r),
    .median_nxt (median_nxt)
  );

  assign diff = (in_adc_sample > last_valid_r) ? (in_adc_sample - last_valid_r)
                                               : (last_valid_r - in_adc_sample);
  assign count_inc   = count_r + CntW'(1);
  assign gather_done = (count_inc == CntW'(SAMPLES));

  always_comb begin
    gathering_nxt  = gathering_r;
    count_nxt      = count_r;
    last_valid_nxt = last_valid_r;
    res_en         = 1'b0;
    temp_sel       = in_adc_sample;
    if (in_acc) begin
      if (gathering_r) begin
        if (gather_done) begin
          gathering_nxt  = 1'b0;
          count_nxt      = '0;
          last_valid_nxt = median_nxt;
          temp_sel       = median_nxt;
          res_en         = 1'b1;
        end else begin
          count_nxt = count_inc;
        end
      end else if (diff >= cfg_r.outlier) begin
        // outlier: drop it and regather
        gathering_nxt = 1'b1;
        count_nxt     = '0;
      end else begin
        res_en = 1'b1;
      end
    end
  end

  mqfs_decide u_decide (
    .temp (temp_sel),
    .echo (in_echo_time),
    .cfg  (cfg_r),
    .res  (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gathering_r  <= 1'b1;
      count_r      <= '0;
      last_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      gathering_r  <= gathering_nxt;
      count_r      <= count_nxt;
      last_valid_r <= last_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_en) begin
      out_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_fan_duty         = out_r.duty;
  assign out_temperature_code = out_r.temp;
  assign out_distance_cm      = out_r.dist_cm;
  assign out_distance_error   = out_r.err;

endmodule

// ===== test/median_qualified_fan_speed_top_tb.sv =====
// Self-checking testbench for the median-qualified fan speed controller.
module median_qualified_fan_speed_top_tb;
  import mqfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSAMP = SamplesDefault;
  localparam int unsigned READINGS_PER_PHASE = 140;
  localparam int unsigned NUM_PHASES = 10;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;

  // indexes past the last register; writes there must be ignored
  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [EchoW-1:0] echo;
  } reading_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CodeW-1:0]    in_adc_sample = '0;
  logic [EchoW-1:0]    in_echo_time = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DutyW-1:0]    out_fan_duty;
  logic [CodeW-1:0]    out_temperature_code;
  logic [DistOutW-1:0] out_distance_cm;
  logic                out_distance_error;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  median_qualified_fan_speed_top #(.SAMPLES(NSAMP)) uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_adc_sample        (in_adc_sample),
    .in_echo_time         (in_echo_time),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_fan_duty         (out_fan_duty),
    .out_temperature_code (out_temperature_code),
    .out_distance_cm      (out_distance_cm),
    .out_distance_error   (out_distance_error),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the controller
  mqfs_cfg_t        regs_now;
  logic             gathering = 1'b1;
  int unsigned      chain_fill = 0;
  logic [CodeW-1:0] chain_codes [NSAMP];
  logic [CodeW-1:0] last_good = '0;

  reading_t    readings_pending [$];
  mqfs_res_t   fan_results_due [$];
  reading_t    next_reading;
  mqfs_res_t   seen;
  mqfs_res_t   due;
  logic        in_taken = 1'b0;
  int unsigned beats_planned = 0;
  int unsigned beats_taken = 0;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  task automatic apply_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    case (idx)
      REG_BAND_LOW:  regs_now.band_low  = val[CodeW-1:0];
      REG_BAND_MID:  regs_now.band_mid  = val[CodeW-1:0];
      REG_BAND_HIGH: regs_now.band_high = val[CodeW-1:0];
      REG_OUTLIER:   regs_now.outlier   = val[CodeW-1:0];
      REG_NEAR:      regs_now.near_cm   = val[NearW-1:0];
      REG_MAX:       regs_now.max_cm    = val[DistW-1:0];
      default: ;
    endcase
  endtask

  task automatic predict_fan_result(input logic [CodeW-1:0] code,
                                    input logic [EchoW-1:0] echo);
    mqfs_res_t        res;
    logic [CodeW-1:0] used;
    int unsigned      pos;
    int unsigned      gap;
    int unsigned      dist_full;
    if (gathering) begin
      pos = chain_fill;
      if (pos < NSAMP) begin
        while (pos > 0 && chain_codes[pos-1] > code) begin
          chain_codes[pos] = chain_codes[pos-1];
          pos--;
        end
        chain_codes[pos] = code;
        chain_fill++;
      end
      if (chain_fill < NSAMP) return;
      used = chain_codes[NSAMP/2];
      last_good = used;
      gathering = 1'b0;
      chain_fill = 0;
    end else begin
      gap = (code > last_good) ? code - last_good : last_good - code;
      if (gap >= regs_now.outlier) begin
        // outlier: dropped, start a fresh median
        gathering = 1'b1;
        chain_fill = 0;
        return;
      end
      used = code;
    end
    dist_full = (32'(echo) * 17) / 1000;
    res.temp = used;
    if (dist_full > regs_now.max_cm) begin
      res.err     = 1'b1;
      res.dist_cm = '0;
      res.duty    = DUTY_OFF;
    end else begin
      res.err     = 1'b0;
      res.dist_cm = (dist_full > DIST_SAT) ? DIST_SAT[DistOutW-1:0] : DistOutW'(dist_full);
      if (dist_full < regs_now.near_cm)   res.duty = DUTY_OFF;
      else if (used < regs_now.band_low)  res.duty = DUTY_OFF;
      else if (used < regs_now.band_mid)  res.duty = DUTY_LOW;
      else if (used < regs_now.band_high) res.duty = DUTY_MID;
      else                                res.duty = DUTY_FULL;
    end
    fan_results_due.push_back(res);
  endtask

  // Input driver and receiver stalls
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (readings_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_reading = readings_pending.pop_front();
          in_adc_sample <= next_reading.code;
          in_echo_time  <= next_reading.echo;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Monitor: predict on input beats, check output beats
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_fan_result(in_adc_sample, in_echo_time);
        beats_taken++;
      end
      if (out_valid && !out_stall) begin
        if (fan_results_due.size() == 0) begin
          $error("result beat with nothing expected");
          fault_count++;
        end else begin
          due = fan_results_due.pop_front();
          seen = '{out_fan_duty, out_temperature_code, out_distance_cm, out_distance_error};
          if (seen.duty !== due.duty) begin
            $error("fan_duty: expected %0d, got %0d", due.duty, seen.duty);
            fault_count++;
          end
          if (seen.temp !== due.temp) begin
            $error("temperature_code: expected %0d, got %0d", due.temp, seen.temp);
            fault_count++;
          end
          if (seen.dist_cm !== due.dist_cm) begin
            $error("distance_cm: expected %0d, got %0d", due.dist_cm, seen.dist_cm);
            fault_count++;
          end
          if (seen.err !== due.err) begin
            $error("distance_error: expected %0d, got %0d", due.err, seen.err);
            fault_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("median_qualified_fan_speed_top_tb failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgDataW'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, CfgDataW'(val));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_reading(input int unsigned code, input int unsigned echo);
    reading_t r;
    r.code = CodeW'(code);
    r.echo = EchoW'(echo);
    readings_pending.push_back(r);
    beats_planned++;
  endtask

  function automatic int unsigned clamp(input int v, input int unsigned top);
    if (v < 0) return 0;
    if (v > int'(top)) return top;
    return v;
  endfunction

  function automatic int spread(input int unsigned w);
    return int'($urandom_range(0, 2 * w)) - int'(w);
  endfunction

  function automatic int unsigned pick_echo();
    int d;
    case ($urandom_range(0, 9))
      0, 1, 2: d = int'(regs_now.near_cm) + spread(3);
      3, 4:    d = int'(regs_now.max_cm) + spread(3);
      5, 6, 7: d = $urandom_range(0, regs_now.max_cm + 10);
      default: return $urandom_range(0, 65535);
    endcase
    if (d < 0) d = 0;
    return clamp((d * 1000 + 16) / 17 + int'($urandom_range(0, 58)), 65535);
  endfunction

  function automatic int unsigned pick_center();
    case ($urandom_range(0, 3))
      0:       return clamp(int'(regs_now.band_low) + spread(12), 1023);
      1:       return clamp(int'(regs_now.band_mid) + spread(12), 1023);
      2:       return clamp(int'(regs_now.band_high) + spread(12), 1023);
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  // Gathers of tightly grouped codes, then mostly in-range readings and some noise
  task automatic make_readings(input int unsigned count);
    int unsigned made;
    int unsigned center;
    int unsigned width;
    made = 0;
    while (made < count) begin
      center = pick_center();
      repeat (NSAMP) begin
        push_reading(clamp(int'(center) + spread(2), 1023), pick_echo());
        made++;
      end
      width = (regs_now.outlier > 3) ? regs_now.outlier - 3 : 0;
      if (width > 20) width = 20;
      repeat ($urandom_range(0, 24)) begin
        if ($urandom_range(0, 99) < 85)
          push_reading(clamp(int'(center) + spread(width), 1023), pick_echo());
        else
          push_reading($urandom_range(0, 1023), pick_echo());
        made++;
      end
    end
  endtask

  task automatic settle();
    while (!(beats_taken == beats_planned && fan_results_due.size() == 0)) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic int unsigned cfg_word(input int unsigned lo, input int unsigned hi);
    // now and then a full-width word to exercise masking
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 2047);
    return $urandom_range(lo, hi);
  endfunction

  task automatic random_config();
    int unsigned base;
    int unsigned mid;
    base = $urandom_range(0, 900);
    mid = clamp(int'(base + $urandom_range(0, 60)), 1023);
    if ($urandom_range(0, 4) == 0) begin
      write_reg(REG_BAND_LOW, cfg_word(0, 1023));
      write_reg(REG_BAND_MID, cfg_word(0, 1023));
      write_reg(REG_BAND_HIGH, cfg_word(0, 1023));
    end else begin
      write_reg(REG_BAND_LOW, base);
      write_reg(REG_BAND_MID, mid);
      write_reg(REG_BAND_HIGH, clamp(int'(mid + $urandom_range(0, 60)), 1023));
    end
    if ($urandom_range(0, 9) == 0) write_reg(REG_OUTLIER, cfg_word(0, 1023));
    else write_reg(REG_OUTLIER, $urandom_range(2, 40));
    write_reg(REG_NEAR, cfg_word(0, 300));
    write_reg(REG_MAX, cfg_word(0, 1114));
    if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE_A, $urandom_range(0, 2047));
  endtask

  initial begin
    int unsigned phase;
    regs_now = '{BAND_LOW_RST, BAND_MID_RST, BAND_HIGH_RST, OUTLIER_RST, NEAR_RST, MAX_RST};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings, no idling: extremes, bands, near/error edges, outliers
    @(posedge clk);
    push_reading(1023, 65535);
    push_reading(0, 0);
    push_reading(150, 100);
    push_reading(150, 200);
    push_reading(150, 300);
    push_reading(151, 400);
    push_reading(149, 500);
    push_reading(150, 600);
    push_reading(150, 700);
    push_reading(152, 3000);   // median 150, 51 cm, low duty
    push_reading(155, 2941);   // 49 cm: person near
    push_reading(160, 17647);  // 299 cm, mid duty
    push_reading(144, 17706);  // 301 cm: distance error
    push_reading(145, 17700);  // exactly 300 cm
    push_reading(139, 5000);   // difference equals delta: outlier
    for (int c = 165; c < 175; c++) push_reading(c, (c == 174) ? 65535 : 1000);
    push_reading(171, 5000);   // full duty
    push_reading(181, 5000);   // outlier again
    make_readings(READINGS_PER_PHASE);
    settle();

    for (phase = 1; phase < NUM_PHASES; phase++) begin
      case (phase)
        1: begin
          // everything at or above the bands, outlier only at full swing, saturated distance
          write_reg(REG_BAND_LOW, 0);
          write_reg(REG_BAND_MID, 0);
          write_reg(REG_BAND_HIGH, 0);
          write_reg(REG_OUTLIER, 1023);
          write_reg(REG_NEAR, 0);
          write_reg(REG_MAX, 1114);
        end
        2: begin
          // every non-gather beat is an outlier; almost all distances in error
          write_reg(REG_BAND_LOW, 1023);
          write_reg(REG_BAND_MID, 1023);
          write_reg(REG_BAND_HIGH, 1023);
          write_reg(REG_OUTLIER, 0);
          write_reg(REG_NEAR, 300);
          write_reg(REG_MAX, 0);
        end
        3: begin
          // misordered bands, tightest outlier window
          write_reg(REG_BAND_LOW, 700);
          write_reg(REG_BAND_MID, 400);
          write_reg(REG_BAND_HIGH, 100);
          write_reg(REG_OUTLIER, 1);
          write_reg(REG_SPARE_B, 2047);
          write_reg(REG_NEAR, 1);
          write_reg(REG_MAX, 511);
          write_reg(REG_SPARE_A, 0);
        end
        default: random_config();
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 70; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 70; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      @(posedge clk);
      make_readings(READINGS_PER_PHASE);
      settle();
    end

    if (fault_count == 0 && fan_results_due.size() == 0)
      $display("median_qualified_fan_speed_top_tb passed");
    else
      $display("median_qualified_fan_speed_top_tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mqfs_pkg.sv
hdl/mqfs_cell.sv
hdl/mqfs_chain.sv
hdl/mqfs_decide.sv
hdl/median_qualified_fan_speed_top.sv
test/median_qualified_fan_speed_top_tb.sv
